### src/jcg_pkg.sv
// ----------------------------------------------------------------------------
// jcg_pkg
// Types, register indexes and curve tables for the joystick command gate.
// ----------------------------------------------------------------------------
`default_nettype none
package jcg_pkg;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [47:0]        now_time;
		logic               enable_input;
		logic [31:0]        session_tag;
		logic [31:0]        source_seq;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
	} in_beat_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] pitch_offset;
		logic signed [15:0] turn_rate;
		logic signed [15:0] linear_velocity;
		logic               stop_flag;
		logic [31:0]        command_seq;
		logic [47:0]        stamp;
		logic [31:0]        session_out;
	} out_beat_t;

	typedef enum logic [1:0] {
		CMD_MODE  = 2'd0,
		CMD_JOY   = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_SPARE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_STRATEGY = 3'd0,
		REG_DEAD     = 3'd1,
		REG_EXPO     = 3'd2,
		REG_PITCH    = 3'd3,
		REG_TURN     = 3'd4,
		REG_SPEED    = 3'd5,
		REG_TIMEOUT  = 3'd6,
		REG_NONE     = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		LN_IDLE, LN_SQR, LN_LOGN, LN_EXP, LN_FIN, LN_SCALE, LN_DONE
	} lane_state_t;

	typedef enum logic [1:0] {
		GT_IDLE, GT_WAIT, GT_EMIT
	} gate_state_t;

	typedef struct packed {
		logic [14:0] dead_zone;
		logic [14:0] curve_exponent;
		logic [14:0] full_scale;
	} lane_cfg_t;

	function automatic longint unsigned jcg_isqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		longint unsigned x;
		res  = 0;
		bitv = 64'd1 << 62;
		x    = v;
		for (int i = 0; i < 32; i++) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [15:0][29:0] jcg_build_tab();
		logic [15:0][29:0] tab;
		longint unsigned t;
		t = jcg_isqrt(64'd1 << 59);
		tab[0] = t[29:0];
		for (int k = 1; k < 16; k++) begin
			t = jcg_isqrt(t << 30);
			tab[k] = t[29:0];
		end
		return tab;
	endfunction

	localparam logic [15:0][29:0] EXP_TAB = jcg_build_tab();

endpackage
`default_nettype wire

### src/jcg_axis_lane.sv
// ----------------------------------------------------------------------------
// jcg_axis_lane
// One axis: deadzone, log2/exp2 power curve, scaling, sign inverted.
// ----------------------------------------------------------------------------
`default_nettype none
module jcg_axis_lane (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic signed [15:0] axis,
	input  wire jcg_pkg::lane_cfg_t cfg,
	output logic                   done,
	output logic signed [15:0]     result
);

	jcg_pkg::lane_state_t st_q, st_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [30:0] f_q, f_d;
	logic [15:0] frac_q, frac_d;
	logic [3:0]  p_q, p_d;
	logic [6:0]  ip_q, ip_d;
	logic [15:0] fp_q, fp_d;
	logic [30:0] v_q, v_d;
	logic [15:0] c_q, c_d;
	logic        neg_q, neg_d;
	logic signed [15:0] res_q, res_d;

	logic [16:0] mag;
	logic [3:0]  pos;
	logic [61:0] sq_prod;
	logic [31:0] sq;
	logic [19:0] n_val;
	logic [34:0] nl;
	logic [22:0] l_val;
	logic [60:0] ex_prod;
	logic [5:0]  sh;
	logic [36:0] fin_sum;
	logic [36:0] fin_r;
	logic [30:0] sc_prod;

	always_comb begin
		mag = axis[15] ? (17'd0 - {axis[15], axis}) : {1'b0, axis};
		pos = 4'd0;
		for (int i = 0; i < 15; i++) begin
			if (mag[i]) pos = 4'(i);
		end
		sq_prod = 62'(f_q) * 62'(f_q);
		sq      = sq_prod[61:30];
		n_val   = {(4'd15 - p_q), 16'd0} - 20'(frac_q);
		nl      = 35'(n_val) * 35'(cfg.curve_exponent) + 35'd2048;
		l_val   = nl[34:12];
		ex_prod = 61'(v_q) * 61'(jcg_pkg::EXP_TAB[cnt_q]) + (61'd1 << 29);
		sh      = 6'd15 + 6'(ip_q);
		fin_sum = 37'(v_q) + (37'd1 << (sh - 6'd1));
		fin_r   = fin_sum >> sh;
		sc_prod = 31'(cfg.full_scale) * 31'(c_q) + 31'd16384;

		st_d = st_q; cnt_d = cnt_q; f_d = f_q; frac_d = frac_q; p_d = p_q;
		ip_d = ip_q; fp_d = fp_q; v_d = v_q; c_d = c_q; neg_d = neg_q;
		res_d = res_q;
		unique case (st_q) inside
			jcg_pkg::LN_IDLE, jcg_pkg::LN_DONE: begin
				if (start) begin
					neg_d = axis[15];
					if (mag < 17'(cfg.dead_zone) || mag == 17'd0) begin
						c_d  = 16'd0;
						st_d = jcg_pkg::LN_SCALE;
					end else if (mag[15]) begin
						c_d  = 16'd32768;
						st_d = jcg_pkg::LN_SCALE;
					end else begin
						p_d    = pos;
						f_d    = 31'(mag[14:0]) << (5'd30 - 5'(pos));
						frac_d = 16'd0;
						cnt_d  = 4'd0;
						st_d   = jcg_pkg::LN_SQR;
					end
				end
			end
			jcg_pkg::LN_SQR: begin
				frac_d = {frac_q[14:0], sq[31]};
				f_d    = sq[31] ? sq[31:1] : sq[30:0];
				cnt_d  = cnt_q + 4'd1;
				if (cnt_q == 4'd15) st_d = jcg_pkg::LN_LOGN;
			end
			jcg_pkg::LN_LOGN: begin
				ip_d  = l_val[22:16];
				fp_d  = l_val[15:0];
				v_d   = 31'd1 << 30;
				cnt_d = 4'd0;
				if (l_val[22:16] > 7'd20) begin
					c_d  = 16'd0;
					st_d = jcg_pkg::LN_SCALE;
				end else begin
					st_d = jcg_pkg::LN_EXP;
				end
			end
			jcg_pkg::LN_EXP: begin
				if (fp_q[4'd15 - cnt_q]) v_d = ex_prod[60:30];
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd15) st_d = jcg_pkg::LN_FIN;
			end
			jcg_pkg::LN_FIN: begin
				c_d  = (fin_r > 37'd32768) ? 16'd32768 : fin_r[15:0];
				st_d = jcg_pkg::LN_SCALE;
			end
			jcg_pkg::LN_SCALE: begin
				res_d = neg_q ? $signed(sc_prod[30:15]) : -$signed(sc_prod[30:15]);
				st_d  = jcg_pkg::LN_DONE;
			end
			default: st_d = jcg_pkg::LN_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= jcg_pkg::LN_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_d; f_q <= f_d; frac_q <= frac_d; p_q <= p_d;
		ip_q <= ip_d; fp_q <= fp_d; v_q <= v_d; c_q <= c_d;
		neg_q <= neg_d; res_q <= res_d;
	end

	assign done   = (st_q == jcg_pkg::LN_DONE);
	assign result = res_q;

endmodule
`default_nettype wire

### src/joystick_command_gate_unit.sv
// ----------------------------------------------------------------------------
// joystick_command_gate_unit
// Gates mode, joystick and tick beats into pitch/turn or linear commands.
// ----------------------------------------------------------------------------
//  channel | signals                            | beat moves when
//  in      | in_valid in_stall in_data          | in_valid & !in_stall
//  out     | out_valid out_stall out_data       | out_valid & !out_stall
//  apb     | psel penable pwrite paddr pwdata   | psel & penable & pwrite
// Mode and tick beats go from idle straight to emit; joystick beats that reach
// the curve wait for up to two 16-step loops (log2 squaring, exp2 product)
// of each axis lane. Both axes run in parallel lanes. in_stall is high while
// a beat is in work or its result waits for a busy output register.
// Reset restores state, session and config registers, not the data registers.
// ----------------------------------------------------------------------------
`default_nettype none
module joystick_command_gate_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire jcg_pkg::in_beat_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output jcg_pkg::out_beat_t       out_data,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic        strat_q;
	logic [14:0] dead_q, expo_q, pmax_q, tmax_q, smax_q;
	logic [31:0] tout_q;

	logic        acc_q, acc_d, to_q, to_d;
	logic [31:0] arm_q, arm_d, lsrc_q, lsrc_d, sarm_q, sarm_d, seq_q, seq_d;
	logic [47:0] ltime_q, ltime_d;
	logic signed [15:0] pt_q, pt_d, tt_q, tt_d;

	jcg_pkg::gate_state_t st_q, st_d;
	jcg_pkg::out_beat_t res_q, res_d, outr_q;
	logic has_q, has_d, wasto_q, wasto_d, lin_q, lin_d;
	logic outv_q;
	logic start;

	jcg_pkg::lane_cfg_t cfg_x, cfg_y;
	logic done_x, done_y;
	logic signed [15:0] val_x, val_y;

	logic        accept, lin, changed, had, drain;
	logic [31:0] seq_inc;
	logic [47:0] elapsed;
	jcg_pkg::reg_idx_t widx;

	assign pready = 1'b1;
	assign widx   = jcg_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strat_q <= 1'b0; dead_q <= 15'd3277; expo_q <= 15'd6144;
			pmax_q <= 15'd1280; tmax_q <= 15'd960; smax_q <= 15'd2048;
			tout_q <= 32'd500000;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				jcg_pkg::REG_STRATEGY: strat_q <= pwdata[0];
				jcg_pkg::REG_DEAD:     dead_q  <= pwdata[14:0];
				jcg_pkg::REG_EXPO:     expo_q  <= pwdata[14:0];
				jcg_pkg::REG_PITCH:    pmax_q  <= pwdata[14:0];
				jcg_pkg::REG_TURN:     tmax_q  <= pwdata[14:0];
				jcg_pkg::REG_SPEED:    smax_q  <= pwdata[14:0];
				jcg_pkg::REG_TIMEOUT:  tout_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			jcg_pkg::REG_STRATEGY: prdata = {31'd0, strat_q};
			jcg_pkg::REG_DEAD:     prdata = {17'd0, dead_q};
			jcg_pkg::REG_EXPO:     prdata = {17'd0, expo_q};
			jcg_pkg::REG_PITCH:    prdata = {17'd0, pmax_q};
			jcg_pkg::REG_TURN:     prdata = {17'd0, tmax_q};
			jcg_pkg::REG_SPEED:    prdata = {17'd0, smax_q};
			jcg_pkg::REG_TIMEOUT:  prdata = tout_q;
			default:               prdata = 32'd0;
		endcase
	end

	assign lin   = strat_q;
	assign cfg_x = '{dead_zone: dead_q, curve_exponent: expo_q, full_scale: tmax_q};
	assign cfg_y = '{dead_zone: dead_q, curve_exponent: expo_q,
		full_scale: (lin ? smax_q : pmax_q)};

	jcg_axis_lane u_lane_x (
		.clk(clk), .arst_n(arst_n), .start(start), .axis(in_data.axis_x),
		.cfg(cfg_x), .done(done_x), .result(val_x)
	);

	jcg_axis_lane u_lane_y (
		.clk(clk), .arst_n(arst_n), .start(start), .axis(in_data.axis_y),
		.cfg(cfg_y), .done(done_y), .result(val_y)
	);

	assign in_stall = (st_q != jcg_pkg::GT_IDLE);
	assign accept   = in_valid && !in_stall;
	assign drain    = !outv_q || !out_stall;

	always_comb begin
		acc_d = acc_q; to_d = to_q; arm_d = arm_q; lsrc_d = lsrc_q;
		sarm_d = sarm_q; seq_d = seq_q; ltime_d = ltime_q; pt_d = pt_q;
		tt_d = tt_q; st_d = st_q; res_d = res_q; has_d = has_q;
		wasto_d = wasto_q; lin_d = lin_q; start = 1'b0;
		seq_inc = (seq_q + 32'd1 == 32'd0) ? 32'd1 : seq_q + 32'd1;
		changed = (arm_q != in_data.session_tag);
		had     = (pt_q != 16'sd0) || (tt_q != 16'sd0);
		elapsed = in_data.now_time - ltime_q;
		unique case (st_q)
			jcg_pkg::GT_IDLE: begin
				if (accept) begin
					res_d = '0;
					has_d = 1'b0;
					st_d  = jcg_pkg::GT_EMIT;
					case (jcg_pkg::cmd_t'(in_data.cmd))
						jcg_pkg::CMD_MODE: begin
							if (in_data.session_tag >= arm_q) begin
								acc_d = in_data.enable_input;
								arm_d = in_data.session_tag;
								res_d.session_out = in_data.session_tag;
								if (changed || !in_data.enable_input) begin
									lsrc_d = 32'd0;
									sarm_d = in_data.session_tag;
								end
								if (in_data.enable_input && (!acc_q || changed)) begin
									pt_d = '0; tt_d = '0; to_d = 1'b1;
									ltime_d = in_data.now_time;
									has_d = 1'b1;
								end else if (!in_data.enable_input && (acc_q || changed)) begin
									pt_d = '0; tt_d = '0; to_d = 1'b1;
									has_d = lin || had;
								end
								if (has_d && lin) begin
									seq_d = seq_inc;
									res_d.kind = 1'b1;
									res_d.stop_flag = 1'b1;
									res_d.command_seq = seq_inc;
									res_d.stamp = in_data.now_time;
								end
							end
						end
						jcg_pkg::CMD_JOY: begin
							if (!(acc_q && lin && (changed || in_data.source_seq == 32'd0 ||
								(sarm_q == arm_q && in_data.source_seq <= lsrc_q)))) begin
								ltime_d = in_data.now_time;
								wasto_d = to_q;
								to_d    = 1'b0;
								if (acc_q) begin
									lin_d = lin;
									start = 1'b1;
									st_d  = jcg_pkg::GT_WAIT;
									res_d.session_out = arm_q;
									if (lin) begin
										sarm_d = arm_q;
										lsrc_d = in_data.source_seq;
										seq_d  = seq_inc;
										res_d.kind = 1'b1;
										res_d.command_seq = seq_inc;
										res_d.stamp = in_data.now_time;
									end
								end
							end
						end
						jcg_pkg::CMD_TICK: begin
							if (acc_q && !to_q && elapsed > 48'(tout_q)) begin
								pt_d = '0; tt_d = '0; to_d = 1'b1;
								has_d = lin || had;
								res_d.session_out = arm_q;
								if (lin) begin
									seq_d = seq_inc;
									res_d.kind = 1'b1;
									res_d.stop_flag = 1'b1;
									res_d.command_seq = seq_inc;
									res_d.stamp = in_data.now_time;
								end
							end
						end
						default: ;
					endcase
				end
			end
			jcg_pkg::GT_WAIT: begin
				if (done_x && done_y) begin
					st_d = jcg_pkg::GT_EMIT;
					if (lin_q) begin
						res_d.linear_velocity = val_y;
						res_d.stop_flag = (val_y == 16'sd0);
						has_d = 1'b1;
					end else if (wasto_q || val_y != pt_q || val_x != tt_q) begin
						pt_d = val_y; tt_d = val_x;
						res_d.pitch_offset = val_y;
						res_d.turn_rate = val_x;
						has_d = 1'b1;
					end
				end
			end
			jcg_pkg::GT_EMIT: begin
				if (!has_q || drain) st_d = jcg_pkg::GT_IDLE;
			end
			default: st_d = jcg_pkg::GT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= jcg_pkg::GT_IDLE;
			acc_q <= 1'b0; to_q <= 1'b1; arm_q <= '0; lsrc_q <= '0;
			sarm_q <= '0; seq_q <= '0; ltime_q <= '0; pt_q <= '0; tt_q <= '0;
			has_q <= 1'b0; wasto_q <= 1'b0; lin_q <= 1'b0;
			outv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			acc_q <= acc_d; to_q <= to_d; arm_q <= arm_d; lsrc_q <= lsrc_d;
			sarm_q <= sarm_d; seq_q <= seq_d; ltime_q <= ltime_d;
			pt_q <= pt_d; tt_q <= tt_d;
			has_q <= has_d; wasto_q <= wasto_d; lin_q <= lin_d;
			if (st_q == jcg_pkg::GT_EMIT && has_q && drain) begin
				outv_q <= 1'b1;
			end else if (!out_stall) begin
				outv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (st_q == jcg_pkg::GT_EMIT && has_q && drain) outr_q <= res_q;
	end

	assign out_valid = outv_q;
	assign out_data  = outr_q;

endmodule
`default_nettype wire
